>>> hw/rtl/gbrf_pkg.sv
// Shared types and constants for the gated burst release FIFO.
`timescale 1ns / 1ps
package gbrf_pkg;

	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int ID_W = 32;
	localparam int BURST_W = 7;
	localparam int WAIT_W = 7;
	localparam int MAX_BURST = 64;
	localparam logic [BURST_W-1:0] BURST_RESET = BURST_W'(3);

	localparam logic FUNC_ARRIVE = 1'b0;
	localparam logic FUNC_SWITCH = 1'b1;

	typedef enum logic [2:0] {
		KIND_PASS         = 3'd0,
		KIND_QUEUED       = 3'd1,
		KIND_DROPPED      = 3'd2,
		KIND_NONE_WAITING = 3'd3,
		KIND_RELEASED     = 3'd4,
		KIND_ZERO_BURST   = 3'd5
	} gbrf_kind_t;

	typedef struct packed {
		logic            func;
		logic [ID_W-1:0] vehicle_id;
	} gbrf_item_t;

	typedef struct packed {
		gbrf_kind_t        kind;
		logic [ID_W-1:0]   item_id;
		logic              light_green;
		logic [WAIT_W-1:0] waiting_count;
		logic              last;
	} gbrf_result_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic rd;
		logic load_rel;
	} gbrf_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
		logic burst_go;
		logic rem_one;
	} gbrf_status_t;

endpackage

>>> hw/rtl/gbrf_chan_if.sv
// Valid/ready channel interface carrying one word of payload type T.
`timescale 1ns / 1ps
interface gbrf_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/gbrf_ctrl.sv
// Controller state machine: accepts words and sequences burst releases.
`timescale 1ns / 1ps
module gbrf_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  gbrf_pkg::gbrf_status_t status,
	output gbrf_pkg::gbrf_cmd_t    cmd
);
	import gbrf_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD
	} state_t;

	state_t state_q;
	logic   accept;

	assign item_ready = (state_q == ST_IDLE) && status.out_free;
	assign accept = item_valid && item_ready;

	always_comb begin
		cmd = '0;
		cmd.accept = accept;
		cmd.rd = (state_q == ST_READ);
		cmd.load_rel = (state_q == ST_LOAD) && status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && status.burst_go) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (status.out_free) begin
						state_q <= status.rem_one ? ST_IDLE : ST_READ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/gbrf_dp.sv
// Datapath: ID memory, queue pointers, gate, burst register and output register.
`timescale 1ns / 1ps
module gbrf_dp #(
	parameter int QUEUE_DEPTH = gbrf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gbrf_pkg::gbrf_cmd_t            cmd,
	output gbrf_pkg::gbrf_status_t         status,
	input  gbrf_pkg::gbrf_item_t           item_data,
	input  logic                          cfg_valid,
	input  logic [gbrf_pkg::BURST_W-1:0]   cfg_data,
	output logic                          result_valid,
	output gbrf_pkg::gbrf_result_t         result_data,
	input  logic                          result_ready
);
	import gbrf_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int NW = (CW > BURST_W) ? CW : BURST_W;

	logic [ID_W-1:0]    mem [QUEUE_DEPTH];
	logic [PW-1:0]      head_q;
	logic [PW-1:0]      tail_q;
	logic [CW-1:0]      count_q;
	logic               gate_q;
	logic [BURST_W-1:0] burst_q;
	logic [BURST_W-1:0] rem_q;
	logic [ID_W-1:0]    rd_data_q;
	logic               out_valid_q;
	gbrf_result_t       out_q;

	logic [BURST_W-1:0] burst_cap;
	logic [BURST_W-1:0] burst_n;
	logic               full;
	logic               push;
	logic               acc_emit;
	gbrf_result_t       acc_res;
	logic [PW-1:0]      head_nxt;
	logic [PW-1:0]      tail_nxt;

	assign full = (count_q == CW'(QUEUE_DEPTH));
	assign head_nxt = (head_q == PW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_nxt = (tail_q == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;

	// release count: burst register, clipped to the queue fill and the burst cap
	assign burst_cap = (burst_q > BURST_W'(MAX_BURST)) ? BURST_W'(MAX_BURST) : burst_q;
	assign burst_n = (NW'(count_q) < NW'(burst_cap)) ? BURST_W'(count_q) : burst_cap;

	assign push = cmd.accept && (item_data.func == FUNC_ARRIVE) && !gate_q && !full;

	assign status.out_free = !out_valid_q || result_ready;
	assign status.burst_go = (item_data.func == FUNC_SWITCH) && (count_q != '0) && !gate_q
		&& (burst_n != '0);
	assign status.rem_one = (rem_q == BURST_W'(1));

	always_comb begin
		acc_emit = 1'b1;
		acc_res.kind = KIND_PASS;
		acc_res.item_id = item_data.vehicle_id;
		acc_res.light_green = gate_q;
		acc_res.waiting_count = WAIT_W'(count_q);
		acc_res.last = 1'b1;
		if (item_data.func == FUNC_ARRIVE) begin
			if (gate_q) begin
				acc_res.kind = KIND_PASS;
			end else if (full) begin
				acc_res.kind = KIND_DROPPED;
			end else begin
				acc_res.kind = KIND_QUEUED;
				acc_res.waiting_count = WAIT_W'(count_q + 1'b1);
			end
		end else begin
			acc_res.item_id = '0;
			if (count_q == '0) begin
				acc_res.kind = KIND_NONE_WAITING;
				acc_res.light_green = !gate_q;
			end else begin
				// both remaining cases leave the gate red
				acc_res.light_green = 1'b0;
				acc_res.kind = KIND_ZERO_BURST;
				acc_emit = !gate_q && (burst_n == '0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[tail_q] <= item_data.vehicle_id;
		end
		if (cmd.rd) begin
			rd_data_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && acc_emit) begin
			out_q <= acc_res;
		end else if (cmd.load_rel) begin
			out_q.kind <= KIND_RELEASED;
			out_q.item_id <= rd_data_q;
			out_q.light_green <= 1'b0;
			out_q.waiting_count <= WAIT_W'(count_q);
			out_q.last <= status.rem_one;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			gate_q <= 1'b0;
			burst_q <= BURST_RESET;
			rem_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				burst_q <= cfg_data;
			end
			if (push) begin
				tail_q <= tail_nxt;
				count_q <= count_q + 1'b1;
			end
			if (cmd.accept && (item_data.func == FUNC_SWITCH)) begin
				// toggle only sticks when the queue is empty; otherwise end red
				gate_q <= (count_q == '0) ? !gate_q : 1'b0;
				if (status.burst_go) begin
					rem_q <= burst_n;
				end
			end
			if (cmd.rd) begin
				head_q <= head_nxt;
				count_q <= count_q - 1'b1;
			end
			if (cmd.load_rel) begin
				rem_q <= rem_q - 1'b1;
			end
			if ((cmd.accept && acc_emit) || cmd.load_rel) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result_data = out_q;

endmodule

>>> hw/rtl/gated_burst_release_fifo_top.sv
// Top level of the gated burst release FIFO.
//
//  channel  | dir | payload                                            | accepted when
//  ---------+-----+----------------------------------------------------+--------------
//  item     | in  | func, vehicle_id                                   | valid & ready
//  result   | out | kind, item_id, light_green, waiting_count, last    | valid & ready
//  cfg      | in  | burst_length                                       | valid (ready high)
//
// An arrival or switch word is accepted on valid & ready; its result sits in the output
// register from the next cycle. Each release of a burst is a registered read of the
// ID memory followed by the output load, which waits out a stall; item.ready is low
// for the whole burst. A stalled result holds the output register and item.ready.
// Reset clears pointers, count, gate (red) and burst_length (3); the ID memory is
// not cleared and the block is ready right after reset.
`timescale 1ns / 1ps
module gated_burst_release_fifo_top #(
	parameter int QUEUE_DEPTH = gbrf_pkg::QUEUE_DEPTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	gbrf_chan_if.sink    item,
	gbrf_chan_if.source  result,
	gbrf_chan_if.sink    cfg
);
	import gbrf_pkg::*;

	gbrf_cmd_t    cmd;
	gbrf_status_t status;
	logic         item_ready;

	assign item.ready = item_ready;
	assign cfg.ready = 1'b1;

	gbrf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item_ready),
		.status     (status),
		.cmd        (cmd)
	);

	gbrf_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.item_data    (item.data),
		.cfg_valid    (cfg.valid),
		.cfg_data     (cfg.data),
		.result_valid (result.valid),
		.result_data  (result.data),
		.result_ready (result.ready)
	);

endmodule

>>> hw/rtl/gbrf_checker.sv
// Port-level assertions for the gated burst release FIFO, bound to the top level.
`timescale 1ns / 1ps
module gbrf_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  item_ready,
	input logic                  result_valid,
	input logic                  result_ready,
	input gbrf_pkg::gbrf_result_t result_data
);
	import gbrf_pkg::*;

	// a stalled result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_data))
		else $error("result word changed while stalled");

	// no new word while the output register is full and not draining
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |-> !item_ready)
		else $error("input taken while result slot blocked");

	// released words always report a red gate
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_data.kind == KIND_RELEASED) |-> !result_data.light_green)
		else $error("release reported with green gate");

	// only releases can be non-final words
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_data.kind != KIND_RELEASED) |-> result_data.last)
		else $error("single result missing last");

endmodule

bind gated_burst_release_fifo_top gbrf_checker u_gbrf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_data  (result.data)
);
